/* sv/lhsh_pkg.sv */
package lhsh_pkg;

  localparam int PHI_SECTORS = 12;
  localparam int RINGS       = 3;
  localparam int SIDE_BINS   = PHI_SECTORS * RINGS;
  localparam int NUM_BINS    = 2 * SIDE_BINS;
  localparam int IDX_W       = $clog2(NUM_BINS);
  localparam int SEC_W       = 4;
  localparam int RING_W      = 2;
  localparam int ADC_W       = 10;
  localparam int CLU_W       = 16;
  localparam int POS_W       = 16;
  localparam int LAYER_W     = 6;
  localparam int OUT_W       = 32;
  localparam int IN_DATA_W   = 72;
  localparam int CMD_W       = 2;
  localparam int Q_DEPTH     = 4;
  localparam int PROD_W      = 31;
  localparam int CROSS_W     = 32;

  // boundary directions, unit vectors scaled by 2^14
  localparam logic signed [PROD_W-1:0] DIR_C = PROD_W'(15826);
  localparam logic signed [PROD_W-1:0] DIR_S = PROD_W'(4240);
  localparam logic signed [PROD_W-1:0] DIR_D = PROD_W'(11585);

  localparam logic [LAYER_W-1:0] RING0_LO = LAYER_W'(7);
  localparam logic [LAYER_W-1:0] RING0_HI = LAYER_W'(22);
  localparam logic [LAYER_W-1:0] RING1_LO = LAYER_W'(23);
  localparam logic [LAYER_W-1:0] RING1_HI = LAYER_W'(38);
  localparam logic [LAYER_W-1:0] RING2_LO = LAYER_W'(39);
  localparam logic [LAYER_W-1:0] RING2_HI = LAYER_W'(54);

  localparam logic [CLU_W-1:0] MIN_CLUSTERS_RST = CLU_W'(1000);

  localparam logic [CMD_W-1:0] CMD_BEGIN    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_HIT      = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ_BIN = 2'd2;
  localparam logic [CMD_W-1:0] CMD_READ_CNT = 2'd3;

  typedef enum logic [2:0] {
    OP_EVENT,
    OP_ADD,
    OP_READ_BIN,
    OP_READ_CNT,
    OP_READ_ZERO
  } op_code_t;

  typedef struct packed {
    op_code_t           op;
    logic [IDX_W-1:0]   idx;
    logic [ADC_W-1:0]   adc;
  } q_entry_t;

  typedef enum logic {
    B_IDLE,
    B_MEM
  } back_state_t;

endpackage

/* sv/lhsh_front.sv */
module lhsh_front
  import lhsh_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  logic [CMD_W-1:0]     in_tuser,
  input  logic [CLU_W-1:0]     min_clusters,
  input  logic                 q_full,
  output logic                 q_push,
  output q_entry_t             q_wdata
);

  function automatic logic [IDX_W-1:0] bin_index(input logic side,
                                                  input logic [SEC_W-1:0] sec,
                                                  input logic [RING_W-1:0] ring);
    bin_index = (side ? IDX_W'(SIDE_BINS) : IDX_W'(0))
              + IDX_W'(sec) * IDX_W'(RINGS) + IDX_W'(ring);
  endfunction

  logic [CLU_W-1:0]          cluster_count;
  logic                      side;
  logic signed [POS_W-1:0]   hit_x;
  logic signed [POS_W-1:0]   hit_y;
  logic [LAYER_W-1:0]        layer;
  logic [ADC_W-1:0]          adc;
  logic [SEC_W-1:0]          sector_sel;
  logic [RING_W-1:0]         ring_sel;

  assign cluster_count = in_tdata[15:0];
  assign side          = in_tdata[16];
  assign hit_x         = in_tdata[32:17];
  assign hit_y         = in_tdata[48:33];
  assign layer         = in_tdata[54:49];
  assign adc           = in_tdata[64:55];
  assign sector_sel    = in_tdata[68:65];
  assign ring_sel      = in_tdata[70:69];

  logic                      in_acc;
  logic                      ring_ok;
  logic [RING_W-1:0]         ring_dec;
  logic                      sel_ok;
  op_code_t                  op_in;
  logic                      keep_in;
  logic signed [PROD_W-1:0]  xe;
  logic signed [PROD_W-1:0]  ye;

  logic                      accepted_r, accepted_nxt;
  logic                      s1_valid_r, s1_valid_nxt;
  op_code_t                  s1_op_r;
  logic                      s1_keep_r;
  logic                      s1_side_r;
  logic [RING_W-1:0]         s1_ring_r;
  logic [ADC_W-1:0]          s1_adc_r;
  logic [IDX_W-1:0]          s1_idx_r;
  logic                      s1_origin_r;
  logic signed [PROD_W-1:0]  pcx_r, psx_r, pdx_r, pcy_r, psy_r, pdy_r;

  logic signed [CROSS_W-1:0] edge_cross [PHI_SECTORS];
  logic [SEC_W-1:0]          sector;
  logic                      s1_adv;

  assign in_acc = in_tvalid && in_tready;

  always_comb begin
    ring_ok  = 1'b1;
    ring_dec = '0;
    if (layer >= RING0_LO && layer <= RING0_HI) begin
      ring_dec = RING_W'(0);
    end else if (layer >= RING1_LO && layer <= RING1_HI) begin
      ring_dec = RING_W'(1);
    end else if (layer >= RING2_LO && layer <= RING2_HI) begin
      ring_dec = RING_W'(2);
    end else begin
      ring_ok = 1'b0;
    end
  end

  assign sel_ok = (sector_sel < SEC_W'(PHI_SECTORS)) && (ring_sel < RING_W'(RINGS));

  always_comb begin
    case (in_tuser)
      CMD_BEGIN: begin
        op_in   = OP_EVENT;
        keep_in = cluster_count >= min_clusters;
      end
      CMD_HIT: begin
        op_in   = OP_ADD;
        keep_in = accepted_r && ring_ok;
      end
      CMD_READ_BIN: begin
        op_in   = sel_ok ? OP_READ_BIN : OP_READ_ZERO;
        keep_in = 1'b1;
      end
      default: begin
        op_in   = OP_READ_CNT;
        keep_in = 1'b1;
      end
    endcase
  end

  always_comb begin
    accepted_nxt = accepted_r;
    if (in_acc && in_tuser == CMD_BEGIN) begin
      accepted_nxt = cluster_count >= min_clusters;
    end
  end

  assign xe = PROD_W'(hit_x);
  assign ye = PROD_W'(hit_y);

  // an item that makes no queue entry just leaves the stage
  assign s1_adv    = s1_valid_r && (!s1_keep_r || !q_full);
  assign in_tready = !s1_valid_r || s1_adv;
  assign q_push    = s1_valid_r && s1_keep_r && !q_full;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accepted_r <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      accepted_r <= accepted_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r     <= op_in;
      s1_keep_r   <= keep_in;
      s1_side_r   <= side;
      s1_ring_r   <= ring_dec;
      s1_adc_r    <= adc;
      s1_idx_r    <= bin_index(side, sector_sel, ring_sel);
      s1_origin_r <= (hit_x == '0) && (hit_y == '0);
      pcx_r       <= xe * DIR_C;
      psx_r       <= xe * DIR_S;
      pdx_r       <= xe * DIR_D;
      pcy_r       <= ye * DIR_C;
      psy_r       <= ye * DIR_S;
      pdy_r       <= ye * DIR_D;
    end
  end

  // cross(b_k, p) = bx*py - by*px for each boundary direction
  always_comb begin
    edge_cross[0]  =  CROSS_W'(pcy_r) + CROSS_W'(psx_r);
    edge_cross[1]  =  CROSS_W'(pcy_r) - CROSS_W'(psx_r);
    edge_cross[2]  =  CROSS_W'(pdy_r) - CROSS_W'(pdx_r);
    edge_cross[3]  =  CROSS_W'(psy_r) - CROSS_W'(pcx_r);
    edge_cross[4]  = -CROSS_W'(psy_r) - CROSS_W'(pcx_r);
    edge_cross[5]  = -CROSS_W'(pdy_r) - CROSS_W'(pdx_r);
    edge_cross[6]  = -CROSS_W'(pcy_r) - CROSS_W'(psx_r);
    edge_cross[7]  = -CROSS_W'(pcy_r) + CROSS_W'(psx_r);
    edge_cross[8]  = -CROSS_W'(pdy_r) + CROSS_W'(pdx_r);
    edge_cross[9]  = -CROSS_W'(psy_r) + CROSS_W'(pcx_r);
    edge_cross[10] =  CROSS_W'(psy_r) + CROSS_W'(pcx_r);
    edge_cross[11] =  CROSS_W'(pdy_r) + CROSS_W'(pdx_r);
  end

  // lowest matching sector wins; origin falls into sector 0
  always_comb begin
    sector = '0;
    for (int k = PHI_SECTORS - 1; k >= 0; k--) begin
      if (!edge_cross[k][CROSS_W-1] && edge_cross[(k + 1) % PHI_SECTORS][CROSS_W-1]) begin
        sector = SEC_W'(k);
      end
    end
    if (s1_origin_r) begin
      sector = '0;
    end
  end

  always_comb begin
    q_wdata.op  = s1_op_r;
    q_wdata.adc = s1_adc_r;
    q_wdata.idx = (s1_op_r == OP_ADD) ? bin_index(s1_side_r, sector, s1_ring_r) : s1_idx_r;
  end

endmodule

/* sv/lhsh_queue.sv */
module lhsh_queue
  import lhsh_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t wdata,
  input  logic     pop,
  output q_entry_t head,
  output logic     full,
  output logic     empty
);

  localparam int PTR_W = $clog2(Q_DEPTH);
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  q_entry_t            slots [Q_DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;

  assign full  = count_r == CNT_W'(Q_DEPTH);
  assign empty = count_r == '0;
  assign head  = slots[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr_r] <= wdata;
    end
  end

endmodule

/* sv/lhsh_back.sv */
module lhsh_back
  import lhsh_pkg::*;
#(
  parameter int SUM_WIDTH = 32
)
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  q_entry_t         q_head,
  output logic             q_pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata
);

  localparam int WIDE_W = SUM_WIDTH + OUT_W;

  back_state_t            state_r, state_nxt;
  q_entry_t               cur_r;
  logic [SUM_WIDTH-1:0]   bin_mem [NUM_BINS];
  logic [NUM_BINS-1:0]    bin_vld_r;
  logic [SUM_WIDTH-1:0]   rd_data_r;
  logic                   rd_vld_r;
  logic [OUT_W-1:0]       evt_r;
  logic                   out_valid_r;
  logic [OUT_W-1:0]       out_data_r;

  logic                   out_free;
  logic                   mem_rd;
  logic                   mem_wr;
  logic                   cnt_inc;
  logic                   out_load;
  logic [OUT_W-1:0]       out_val;
  logic [SUM_WIDTH-1:0]   sum_base;
  logic [SUM_WIDTH:0]     sum_add;
  logic [SUM_WIDTH-1:0]   wr_data;
  logic [WIDE_W-1:0]      sum_wide;
  logic [OUT_W-1:0]       sum_sat;

  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // a bin never written reads as zero
  assign sum_base = rd_vld_r ? rd_data_r : '0;
  assign sum_add  = {1'b0, sum_base} + (SUM_WIDTH + 1)'(cur_r.adc);
  assign wr_data  = sum_add[SUM_WIDTH] ? '1 : sum_add[SUM_WIDTH-1:0];

  assign sum_wide = WIDE_W'(sum_base);
  assign sum_sat  = (sum_wide[WIDE_W-1:OUT_W] != '0) ? '1 : sum_wide[OUT_W-1:0];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (!q_empty && (q_head.op == OP_ADD || q_head.op == OP_READ_BIN)) begin
          state_nxt = B_MEM;
        end
      end
      B_MEM: begin
        if (cur_r.op == OP_ADD || out_free) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    mem_rd   = 1'b0;
    mem_wr   = 1'b0;
    cnt_inc  = 1'b0;
    out_load = 1'b0;
    out_val  = '0;
    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          case (q_head.op)
            OP_EVENT: begin
              q_pop   = 1'b1;
              cnt_inc = 1'b1;
            end
            OP_READ_CNT: begin
              if (out_free) begin
                q_pop    = 1'b1;
                out_load = 1'b1;
                out_val  = evt_r;
              end
            end
            OP_READ_ZERO: begin
              if (out_free) begin
                q_pop    = 1'b1;
                out_load = 1'b1;
              end
            end
            OP_ADD, OP_READ_BIN: begin
              q_pop  = 1'b1;
              mem_rd = 1'b1;
            end
            default: q_pop = 1'b1;
          endcase
        end
      end
      B_MEM: begin
        if (cur_r.op == OP_ADD) begin
          mem_wr = 1'b1;
        end else if (out_free) begin
          out_load = 1'b1;
          out_val  = sum_sat;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      bin_vld_r   <= '0;
      evt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (mem_wr) begin
        bin_vld_r[cur_r.idx] <= 1'b1;
      end
      if (cnt_inc && evt_r != '1) begin
        evt_r <= evt_r + 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_rd) begin
      cur_r     <= q_head;
      rd_data_r <= bin_mem[q_head.idx];
      rd_vld_r  <= bin_vld_r[q_head.idx];
    end
    if (mem_wr) begin
      bin_mem[cur_r.idx] <= wr_data;
    end
    if (out_load) begin
      out_data_r <= out_val;
    end
  end

  a_mem_op : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_MEM |-> (cur_r.op == OP_ADD || cur_r.op == OP_READ_BIN))
    else $error("memory state holds an op without a bin access");

  a_rd_then_mem : assert property (@(posedge clk) disable iff (!rst_n)
    mem_rd |=> state_r == B_MEM)
    else $error("bin read issued without entering memory state");

  a_pop_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("pop from empty queue");

endmodule

/* sv/laser_hit_sector_histogram.sv */
// Channel  Dir  Handshake               Payload
// in       in   in_tvalid / in_tready   in_tdata (hit fields), in_tuser (cmd)
// out      out  out_tvalid / out_tready out_tdata (read_value)
// cfg      in   cfg_valid / cfg_ready   cfg_data (min_clusters)
//
// The front takes one beat per cycle unless the queue is full. The back handles
// event-begin, count and out-of-range reads from its idle state; a hit or a bin
// read goes through the bin memory read, then the saturating write-back or the
// result. A four-entry queue between front and back absorbs the difference.
// rst_n is synchronous; it clears the bin valid bits, the event count and the
// event flag at once, so no clearing pass is needed.
// A stalled output holds the back; the front keeps filling the queue.
module laser_hit_sector_histogram
  import lhsh_pkg::*;
#(
  parameter int SUM_WIDTH = 32
)
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // cluster_count[15:0], side[16], hit_x[32:17], hit_y[48:33], layer[54:49],
  // adc[64:55], sector_sel[68:65], ring_sel[70:69], zero pad[71]
  input  logic [IN_DATA_W-1:0] in_tdata,
  // cmd[1:0]
  input  logic [CMD_W-1:0]     in_tuser,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // read_value[31:0]
  output logic [OUT_W-1:0]     out_tdata,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CLU_W-1:0]     cfg_data
);

  logic [CLU_W-1:0] min_clusters_r;
  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             q_empty;
  q_entry_t         q_wdata;
  q_entry_t         q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_clusters_r <= MIN_CLUSTERS_RST;
    end else if (cfg_valid && cfg_ready) begin
      min_clusters_r <= cfg_data;
    end
  end

  lhsh_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .min_clusters (min_clusters_r),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_wdata      (q_wdata)
  );

  lhsh_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .head  (q_head),
    .full  (q_full),
    .empty (q_empty)
  );

  lhsh_back #(
    .SUM_WIDTH (SUM_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

/* bench/hit_histogram_checker.sv */
`timescale 1ns / 100ps

module hit_histogram_checker
  import lhsh_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  // cluster_count[15:0], side[16], hit_x[32:17], hit_y[48:33], layer[54:49],
  // adc[64:55], sector_sel[68:65], ring_sel[70:69], zero pad[71]
  input  logic [IN_DATA_W-1:0] in_tdata,
  // cmd[1:0]
  input  logic [CMD_W-1:0]     in_tuser,
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  // read_value[31:0]
  input  logic [OUT_W-1:0]     out_tdata,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CLU_W-1:0]     cfg_data,
  output int                   errors,
  output int                   pending
);

  localparam int SUM_W = 32;
  localparam int COS15 = 15826;
  localparam int SIN15 = 4240;
  localparam int DIAG  = 11585;

  typedef struct packed {
    logic                    pad;
    logic [RING_W-1:0]       ring_sel;
    logic [SEC_W-1:0]        sector_sel;
    logic [ADC_W-1:0]        adc;
    logic [LAYER_W-1:0]      layer;
    logic signed [POS_W-1:0] hit_y;
    logic signed [POS_W-1:0] hit_x;
    logic                    side;
    logic [CLU_W-1:0]        clusters;
  } beat_word_t;

  logic [SUM_W-1:0] bin_sum [NUM_BINS];
  logic [OUT_W-1:0] events_taken;
  logic             event_open;
  logic [CLU_W-1:0] threshold;
  logic [OUT_W-1:0] reads_due [$];
  logic [OUT_W-1:0] want;
  int               err_count = 0;
  int               i;

  // Lower edge of sector k, unit direction scaled by 2^14.
  function automatic void sector_edge(input int k, output longint ex, output longint ey);
    case (k)
      0:       begin ex =  COS15; ey = -SIN15; end
      1:       begin ex =  COS15; ey =  SIN15; end
      2:       begin ex =  DIAG;  ey =  DIAG;  end
      3:       begin ex =  SIN15; ey =  COS15; end
      4:       begin ex = -SIN15; ey =  COS15; end
      5:       begin ex = -DIAG;  ey =  DIAG;  end
      6:       begin ex = -COS15; ey =  SIN15; end
      7:       begin ex = -COS15; ey = -SIN15; end
      8:       begin ex = -DIAG;  ey = -DIAG;  end
      9:       begin ex = -SIN15; ey = -COS15; end
      10:      begin ex =  SIN15; ey = -COS15; end
      default: begin ex =  DIAG;  ey = -DIAG;  end
    endcase
  endfunction

  function automatic int sector_of(input logic signed [POS_W-1:0] px,
                                   input logic signed [POS_W-1:0] py);
    longint x, y, ax, ay, bx, by;
    int     k;
    x = px;
    y = py;
    if (x == 0 && y == 0) return 0;
    for (k = 0; k < PHI_SECTORS; k++) begin
      sector_edge(k, ax, ay);
      sector_edge((k + 1) % PHI_SECTORS, bx, by);
      if (ax * y - ay * x >= 0 && bx * y - by * x < 0) return k;
    end
    return 0;
  endfunction

  function automatic int ring_of(input logic [LAYER_W-1:0] layer);
    if (layer >= 7 && layer <= 22) return 0;
    if (layer >= 23 && layer <= 38) return 1;
    if (layer >= 39 && layer <= 54) return 2;
    return -1;
  endfunction

  task automatic report_mismatch(input string what, input logic [OUT_W-1:0] got,
                                 input logic [OUT_W-1:0] exp_val);
    $display("%0t mismatch on %s: got %0d, want %0d", $time, what, got, exp_val);
    err_count++;
  endtask

  task automatic take_beat(input logic [CMD_W-1:0] cmd, input beat_word_t w);
    int           ring;
    int           idx;
    logic [SUM_W:0] sum;
    case (cmd)
      CMD_BEGIN: begin
        event_open = (w.clusters >= threshold);
        if (event_open && events_taken != '1) events_taken = events_taken + 1'b1;
      end
      CMD_HIT: begin
        ring = ring_of(w.layer);
        if (event_open && ring >= 0) begin
          idx = w.side * SIDE_BINS + sector_of(w.hit_x, w.hit_y) * RINGS + ring;
          sum = bin_sum[idx] + w.adc;
          // saturate at the top of the sum
          bin_sum[idx] = sum[SUM_W] ? '1 : sum[SUM_W-1:0];
        end
      end
      CMD_READ_BIN: begin
        if (w.sector_sel < PHI_SECTORS && w.ring_sel < RINGS)
          reads_due.push_back(bin_sum[w.side * SIDE_BINS + w.sector_sel * RINGS + w.ring_sel]);
        else
          reads_due.push_back('0);
      end
      default: reads_due.push_back(events_taken);
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (i = 0; i < NUM_BINS; i++) bin_sum[i] = '0;
      events_taken = '0;
      event_open   = 1'b0;
      threshold    = MIN_CLUSTERS_RST;
      reads_due.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (reads_due.size() == 0) begin
          report_mismatch("unexpected result beat", out_tdata, '0);
        end else begin
          want = reads_due.pop_front();
          if (out_tdata !== want) report_mismatch("read_value", out_tdata, want);
        end
      end
      if (cfg_valid && cfg_ready) threshold = cfg_data;
      if (in_tvalid && in_tready) take_beat(in_tuser, in_tdata);
    end
    errors  <= err_count;
    pending <= reads_due.size();
  end

endmodule

/* bench/laser_hit_sector_histogram_tb.sv */
`timescale 1ns / 100ps

module laser_hit_sector_histogram_tb;
  import lhsh_pkg::*;

  localparam int RESET_CYCLES = 5;
  localparam int DRAIN_CYCLES = 16;
  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 150;
  localparam int HOLD_AT      = 200;
  localparam int PAUSE_AT     = 500;
  localparam int PHASE_BEATS  = 306;
  localparam int IDLE_PCT     = 21;
  localparam int TX_CALM_FROM = 700;
  localparam int TX_CALM_TO   = 900;
  localparam int RX_CALM_FROM = 1500;
  localparam int RX_CALM_TO   = 1900;
  localparam int COS15        = 15826;
  localparam int SIN15        = 4240;
  localparam int DIAG         = 11585;

  typedef struct packed {
    logic                    pad;
    logic [RING_W-1:0]       ring_sel;
    logic [SEC_W-1:0]        sector_sel;
    logic [ADC_W-1:0]        adc;
    logic [LAYER_W-1:0]      layer;
    logic signed [POS_W-1:0] hit_y;
    logic signed [POS_W-1:0] hit_x;
    logic                    side;
    logic [CLU_W-1:0]        clusters;
  } beat_word_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [IN_DATA_W-1:0] in_tdata;
  logic [CMD_W-1:0]     in_tuser;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [OUT_W-1:0]     out_tdata;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CLU_W-1:0]     cfg_data;
  int                   errors;
  int                   pending;

  logic [CLU_W-1:0]     threshold;
  int                   beats_sent = 0;
  int                   rx_cycles = 0;
  int                   stall_count = 0;
  bit                   hold_req = 1'b0;
  bit                   hold_done = 1'b0;
  bit                   paused = 1'b0;

  always #5 clk = ~clk;

  laser_hit_sector_histogram uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  hit_histogram_checker histogram_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .errors     (errors),
    .pending    (pending)
  );

  function automatic beat_word_t random_word();
    beat_word_t w;
    w = IN_DATA_W'({$urandom(), $urandom(), $urandom()});
    w.pad = 1'b0;
    return w;
  endfunction

  task automatic maybe_idle();
    if ((beats_sent < TX_CALM_FROM || beats_sent >= TX_CALM_TO) &&
        $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
  endtask

  task automatic send_beat(input logic [CMD_W-1:0] cmd, input beat_word_t w);
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= w;
    do @(posedge clk); while (!in_tready);
    beats_sent++;
    maybe_idle();
  endtask

  task automatic begin_beat(input int clusters);
    beat_word_t w;
    w = random_word();
    w.clusters = clusters[CLU_W-1:0];
    send_beat(CMD_BEGIN, w);
  endtask

  task automatic hit_beat(input bit north, input int x, input int y, input int layer,
                          input int adc);
    beat_word_t w;
    w = random_word();
    w.side  = north;
    w.hit_x = x[POS_W-1:0];
    w.hit_y = y[POS_W-1:0];
    w.layer = layer[LAYER_W-1:0];
    w.adc   = adc[ADC_W-1:0];
    send_beat(CMD_HIT, w);
  endtask

  task automatic read_bin_beat(input bit north, input int sec, input int ring);
    beat_word_t w;
    w = random_word();
    w.side       = north;
    w.sector_sel = sec[SEC_W-1:0];
    w.ring_sel   = ring[RING_W-1:0];
    send_beat(CMD_READ_BIN, w);
  endtask

  task automatic read_count_beat();
    send_beat(CMD_READ_CNT, random_word());
  endtask

  // Drop valid and wait until every read has come back and the back end is quiet.
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [CLU_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    threshold = v;
  endtask

  // Cluster count near the threshold most of the time, so both outcomes show up.
  function automatic int event_clusters();
    int n;
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: begin
        n = int'(threshold) + int'($urandom_range(50));
        return (n > 65535) ? 65535 : n;
      end
      6:       return (threshold > 0) ? int'(threshold) - 1 : 0;
      7:       return int'(threshold);
      8:       return int'($urandom_range(65535));
      default: return $urandom_range(1) ? 65535 : 0;
    endcase
  endfunction

  task automatic random_hit();
    int x, y, a, b, m, layer, adc;
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: begin
        x = int'($urandom_range(65535)) - 32768;
        y = int'($urandom_range(65535)) - 32768;
      end
      6, 7: begin
        x = int'($urandom_range(128)) - 64;
        y = int'($urandom_range(128)) - 64;
      end
      default: begin
        // land on a sector edge or one step off it
        case ($urandom_range(2))
          0:       begin a = COS15; b = SIN15; end
          1:       begin a = DIAG;  b = DIAG;  end
          default: begin a = SIN15; b = COS15; end
        endcase
        m = int'($urandom_range(1, 2));
        x = ($urandom_range(1) ? a : -a) * m;
        y = ($urandom_range(1) ? b : -b) * m + int'($urandom_range(2)) - 1;
      end
    endcase
    layer = $urandom_range(4) ? int'($urandom_range(7, 54)) : int'($urandom_range(63));
    if ($urandom_range(9) == 0) adc = $urandom_range(1) ? 1023 : 0;
    else adc = int'($urandom_range(1023));
    hit_beat(1'($urandom_range(1)), x, y, layer, adc);
  endtask

  task automatic random_read();
    if ($urandom_range(4) == 0)
      read_count_beat();
    else if ($urandom_range(6) == 0)
      read_bin_beat(1'($urandom_range(1)), $urandom_range(15), $urandom_range(3));
    else
      read_bin_beat(1'($urandom_range(1)), $urandom_range(11), $urandom_range(2));
  endtask

  task automatic run_phase(input logic [CLU_W-1:0] min_clusters, input int beats);
    int stop;
    settle();
    write_threshold(min_clusters);
    stop = beats_sent + beats;
    while (beats_sent < stop) begin
      if (beats_sent >= HOLD_AT) hold_req <= 1'b1;
      if (beats_sent >= PAUSE_AT && !paused) begin
        paused = 1'b1;
        settle();
      end
      if ($urandom_range(9) == 0) begin
        send_beat(CMD_W'($urandom_range(3)), random_word());
      end else begin
        begin_beat(event_clusters());
        repeat ($urandom_range(10)) begin
          random_hit();
          if ($urandom_range(4) == 0) random_read();
        end
      end
    end
  endtask

  // Result side: random back-pressure, one long hold-off, one calm stretch.
  initial begin
    out_tready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      @(posedge clk);
      rx_cycles++;
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_tready <= (rx_cycles >= RX_CALM_FROM && rx_cycles < RX_CALM_TO) ||
                    ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall_count <= 0;
    end else if (stall_count >= STALL_LIMIT) begin
      $display("laser_hit_sector_histogram_tb: errors");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= CMD_BEGIN;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    threshold = MIN_CLUSTERS_RST;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // reset threshold still in force here
    read_count_beat();
    read_bin_beat(0, 0, 0);
    hit_beat(0, 1000, 0, 7, 1023);
    begin_beat(999);
    hit_beat(1, 0, 1000, 30, 500);
    begin_beat(1000);
    hit_beat(0, 0, 0, 7, 1023);
    hit_beat(0, 5, 5, 6, 100);
    hit_beat(0, 5, 5, 55, 100);
    hit_beat(1, 5, 5, 63, 100);
    hit_beat(1, 5, 5, 0, 100);
    hit_beat(0, -32768, -32768, 54, 0);
    hit_beat(1, 32767, 32767, 22, 1023);
    hit_beat(1, 32767, -32768, 23, 777);
    hit_beat(0, -32768, 32767, 38, 1);
    hit_beat(1, COS15, -SIN15, 39, 600);
    hit_beat(1, SIN15, -COS15, 39, 321);
    read_bin_beat(0, 0, 0);
    read_bin_beat(1, 0, 2);
    read_bin_beat(1, 10, 2);
    read_bin_beat(0, 15, 3);
    read_bin_beat(1, 12, 0);
    begin_beat(0);
    begin_beat(65535);
    read_count_beat();

    run_phase('0, PHASE_BEATS);
    run_phase('1, PHASE_BEATS);
    run_phase(CLU_W'($urandom_range(1, 4000)), PHASE_BEATS);
    run_phase(CLU_W'(1), PHASE_BEATS);
    run_phase(MIN_CLUSTERS_RST, PHASE_BEATS);
    settle();

    if (errors == 0)
      $display("laser_hit_sector_histogram_tb: clean");
    else
      $display("laser_hit_sector_histogram_tb: errors");
    $finish;
  end

endmodule
